/* sv/lbs_pkg.sv */
// ----------------------------------------------------------------------------
// Bresenham line stepper package
// Shared constants and the command code type for the line stepper blocks.
// ----------------------------------------------------------------------------
package lbs_pkg;

    // Default coordinate width and command queue depth.
    localparam int COORD_BITS_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Command codes carried by the opcode field.
    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

endpackage

/* sv/bresenham_line_stepper_core.sv */
// out_valid rises after the input transfer has passed the queue write and then the result register.
// Throughput: one item per cycle; one step is two error compares and two adds on registered state.
// A stalled result port backs up the command queue; the input side stalls once it is full.
// Reset (rst_n, asynchronous, active low) clears the line to the all-zero point, empties
// the queue and drops out_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Bresenham line stepper core
// Top level: front end, command queue and stepping back end.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_core
    import lbs_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  pixel_valid,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  line_done
);

    localparam int CMD_W = 6 * COORD_BITS + 3;

    logic             push_valid;
    logic             push_ready;
    logic [CMD_W-1:0] push_data;
    logic             cmd_valid;
    logic             cmd_ready;
    logic [CMD_W-1:0] cmd_data;

    // Classification and delta precompute.
    lbs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decoupling queue.
    lbs_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_data   (cmd_data)
    );

    // Line state and stepping.
    lbs_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_data    (cmd_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_valid (pixel_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .line_done   (line_done)
    );

endmodule

/* sv/lbs_front.sv */
// ----------------------------------------------------------------------------
// Line stepper front end
// Accepts input items, classifies them and precomputes the step directions
// and axis deltas of a load, then hands a packed command to the queue.
// ----------------------------------------------------------------------------
module lbs_front
    import lbs_pkg::*;
#(
    parameter int  COORD_BITS = COORD_BITS_DEF,
    localparam int CMD_W      = 6 * COORD_BITS + 3
)
(
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  push_valid,
    input  logic                  push_ready,
    output logic [CMD_W-1:0]      push_data
);

    logic                  x_fwd;
    logic                  y_fwd;
    logic [COORD_BITS-1:0] delta_x;
    logic [COORD_BITS-1:0] delta_y;
    op_t                   op;

    // Direction of travel on each axis; equal coordinates take the negative one.
    assign x_fwd = (start_x < end_x);
    assign y_fwd = (start_y < end_y);

    // Absolute distances along each axis.
    assign delta_x = x_fwd ? (end_x - start_x) : (start_x - end_x);
    assign delta_y = y_fwd ? (end_y - start_y) : (start_y - end_y);

    assign op = op_t'(opcode);

    // The queue takes one command per transfer.
    assign push_valid = in_valid;
    assign in_ready   = push_ready;
    assign push_data  = {op, start_x, start_y, end_x, end_y, ~x_fwd, ~y_fwd,
                         delta_x, delta_y};

endmodule

/* sv/lbs_queue.sv */
// ----------------------------------------------------------------------------
// Line stepper command queue
// Short FIFO between the front end and the stepping back end so that each
// side can stall on its own.
// ----------------------------------------------------------------------------
module lbs_queue
    import lbs_pkg::*;
#(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = QUEUE_DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW    = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/lbs_back.sv */
// ----------------------------------------------------------------------------
// Line stepper back end
// Holds the line state, executes load and step commands from the queue and
// drives the registered result port.
// ----------------------------------------------------------------------------
module lbs_back
    import lbs_pkg::*;
#(
    parameter int  COORD_BITS = COORD_BITS_DEF,
    localparam int CMD_W      = 6 * COORD_BITS + 3,
    localparam int ERR_W      = COORD_BITS + 3,
    localparam int TW_W       = COORD_BITS + 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  logic [CMD_W-1:0]      cmd_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  pixel_valid,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  line_done
);

    // Command fields.
    op_t                   cmd_op;
    logic [COORD_BITS-1:0] cmd_sx;
    logic [COORD_BITS-1:0] cmd_sy;
    logic [COORD_BITS-1:0] cmd_ex;
    logic [COORD_BITS-1:0] cmd_ey;
    logic                  cmd_left;
    logic                  cmd_up;
    logic [COORD_BITS-1:0] cmd_dx;
    logic [COORD_BITS-1:0] cmd_dy;

    // Line state.
    logic [COORD_BITS-1:0]   cur_x_reg,   cur_x_next;
    logic [COORD_BITS-1:0]   cur_y_reg,   cur_y_next;
    logic [COORD_BITS-1:0]   tgt_x_reg,   tgt_x_next;
    logic [COORD_BITS-1:0]   tgt_y_reg,   tgt_y_next;
    logic                    left_reg,    left_next;
    logic                    up_reg,      up_next;
    logic [COORD_BITS-1:0]   dx_reg,      dx_next;
    logic signed [COORD_BITS:0] dyn_reg,  dyn_next;
    logic signed [ERR_W-1:0] err_reg,     err_next;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    logic                  pix_valid_reg, pix_valid_next;
    logic [COORD_BITS-1:0] pix_x_reg,     pix_x_next;
    logic [COORD_BITS-1:0] pix_y_reg,     pix_y_next;
    logic                  done_reg,      done_next;

    logic                  take;
    logic                  at_end;
    logic signed [TW_W-1:0] twice;
    logic signed [TW_W-1:0] dyn_ext;
    logic signed [TW_W-1:0] dx_ext;
    logic signed [TW_W-1:0] err_sum;
    logic                  move_x;
    logic                  move_y;

    assign {cmd_op, cmd_sx, cmd_sy, cmd_ex, cmd_ey, cmd_left, cmd_up,
            cmd_dx, cmd_dy} = cmd_data;

    // A command is taken whenever the result register is free or drains now.
    assign cmd_ready = !out_valid_reg || out_ready;
    assign take      = cmd_valid && cmd_ready;

    // Error comparisons against both deltas.
    assign at_end  = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);
    assign twice   = TW_W'(err_reg) <<< 1;
    assign dyn_ext = TW_W'(dyn_reg);
    assign dx_ext  = $signed({{(TW_W - COORD_BITS){1'b0}}, dx_reg});
    assign move_x  = (twice >= dyn_ext);
    assign move_y  = (twice <= dx_ext);
    assign err_sum = TW_W'(err_reg) + (move_x ? dyn_ext : '0) + (move_y ? dx_ext : '0);

    // Next state and next result.
    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        tgt_x_next     = tgt_x_reg;
        tgt_y_next     = tgt_y_reg;
        left_next      = left_reg;
        up_next        = up_reg;
        dx_next        = dx_reg;
        dyn_next       = dyn_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pix_valid_next = pix_valid_reg;
        pix_x_next     = pix_x_reg;
        pix_y_next     = pix_y_reg;
        done_next      = done_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            case (cmd_op)
                OP_LOAD:
                begin
                    cur_x_next     = cmd_sx;
                    cur_y_next     = cmd_sy;
                    tgt_x_next     = cmd_ex;
                    tgt_y_next     = cmd_ey;
                    left_next      = cmd_left;
                    up_next        = cmd_up;
                    dx_next        = cmd_dx;
                    dyn_next       = -$signed({1'b0, cmd_dy});
                    err_next       = $signed({3'b000, cmd_dx}) - $signed({3'b000, cmd_dy});
                    pix_valid_next = 1'b0;
                    pix_x_next     = cmd_sx;
                    pix_y_next     = cmd_sy;
                    done_next      = (cmd_sx == cmd_ex) && (cmd_sy == cmd_ey);
                end
                OP_STEP:
                begin
                    if (at_end)
                    begin
                        pix_valid_next = 1'b0;
                        pix_x_next     = cur_x_reg;
                        pix_y_next     = cur_y_reg;
                        done_next      = 1'b1;
                    end
                    else
                    begin
                        if (move_x)
                        begin
                            cur_x_next = left_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                        end
                        if (move_y)
                        begin
                            cur_y_next = up_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                        end
                        err_next       = err_sum[ERR_W-1:0];
                        pix_valid_next = 1'b1;
                        pix_x_next     = cur_x_next;
                        pix_y_next     = cur_y_next;
                        done_next      = (cur_x_next == tgt_x_reg) && (cur_y_next == tgt_y_reg);
                    end
                end
                default:
                begin
                    pix_valid_next = 1'b0;
                end
            endcase
        end
    end

    // Line state resets to the all-zero line.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            tgt_x_reg     <= '0;
            tgt_y_reg     <= '0;
            left_reg      <= 1'b0;
            up_reg        <= 1'b0;
            dx_reg        <= '0;
            dyn_reg       <= '0;
            err_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            tgt_x_reg     <= tgt_x_next;
            tgt_y_reg     <= tgt_y_next;
            left_reg      <= left_next;
            up_reg        <= up_next;
            dx_reg        <= dx_next;
            dyn_reg       <= dyn_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        pix_valid_reg <= pix_valid_next;
        pix_x_reg     <= pix_x_next;
        pix_y_reg     <= pix_y_next;
        done_reg      <= done_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_valid = pix_valid_reg;
    assign pixel_x     = pix_x_reg;
    assign pixel_y     = pix_y_reg;
    assign line_done   = done_reg;

endmodule

/* sv/lbs_checker.sv */
// ----------------------------------------------------------------------------
// Line stepper port checker
// Watches the top-level ports for result ordering, occupancy and hold rules.
// ----------------------------------------------------------------------------
module lbs_checker
    import lbs_pkg::*;
#(
    parameter int  COORD_BITS  = COORD_BITS_DEF,
    parameter int  QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int OCW         = $clog2(QUEUE_DEPTH + 3)
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  opcode,
    input logic [COORD_BITS-1:0] start_x,
    input logic [COORD_BITS-1:0] start_y,
    input logic [COORD_BITS-1:0] end_x,
    input logic [COORD_BITS-1:0] end_y,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  pixel_valid,
    input logic [COORD_BITS-1:0] pixel_x,
    input logic [COORD_BITS-1:0] pixel_y,
    input logic                  line_done
);

    logic [OCW-1:0] pend_reg;
    logic [OCW-1:0] pend_next;
    logic           in_xfer;
    logic           out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // Items accepted whose result has not been transferred yet.
    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer && !out_xfer)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A result is never shown without an item behind it.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != '0))
        else $error("result shown with no pending item");

    // Pending items never exceed the queue plus the result register.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= OCW'(QUEUE_DEPTH + 1))
        else $error("more items pending than the block can hold");

    // No result is offered in the cycle reset is released.
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_valid)
            && $stable(pixel_x) && $stable(pixel_y) && $stable(line_done))
        else $error("stalled result changed");

endmodule

bind bresenham_line_stepper_core lbs_checker #(
    .COORD_BITS  (COORD_BITS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_lbs_checker (.*);
